>>> rtl/tocg_pkg.sv
// Shared types, opcodes and font tables for the text overlay character generator.
// Depends on nothing; every other file imports it.

package tocg_pkg;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam int CELL_W    = 6;
	localparam int CELL_H    = 8;
	localparam int GLYPH_W   = 5;
	localparam int GLYPH_H   = 7;
	localparam int FONT_SIZE = 42;

	localparam logic [5:0] NO_GLYPH = 6'd42;
	localparam logic [7:0] LIT      = 8'hFF;
	localparam logic [7:0] DARK     = 8'h00;

	typedef logic [5:0]  glyph_idx_t;
	typedef logic [6:0]  glyph_col_t;
	typedef logic [34:0] glyph_bits_t;

	typedef struct packed {
		logic clear;
		logic write;
		logic erase;
		logic read;
	} mem_cmd_t;

	function automatic glyph_idx_t glyph_index(input logic [7:0] code);
		logic [7:0] c;
		glyph_idx_t idx;
		c = code;
		if (c >= 8'h61 && c <= 8'h7A)
			c = c - 8'h20;
		idx = NO_GLYPH;
		if (c == 8'h20)
			idx = 6'd0;
		else if (c >= 8'h30 && c <= 8'h39)
			idx = 6'(c - 8'h30 + 8'd1);
		else if (c >= 8'h41 && c <= 8'h5A)
			idx = 6'(c - 8'h41 + 8'd11);
		else if (c == 8'h3A)
			idx = 6'd37;
		else if (c == 8'h2F)
			idx = 6'd38;
		else if (c == 8'h2E)
			idx = 6'd39;
		else if (c == 8'h2D)
			idx = 6'd40;
		else if (c == 8'h25)
			idx = 6'd41;
		return idx;
	endfunction

	// Left column in the top bits; bit 0 of a column is the top pixel row.
	function automatic glyph_bits_t font_bits(input glyph_idx_t idx);
		glyph_bits_t g;
		unique case (idx)
			6'd0:  g = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
			6'd1:  g = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
			6'd2:  g = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
			6'd3:  g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
			6'd4:  g = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
			6'd5:  g = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
			6'd6:  g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
			6'd7:  g = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
			6'd8:  g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
			6'd9:  g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
			6'd10: g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
			6'd11: g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
			6'd12: g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
			6'd13: g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
			6'd14: g = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
			6'd15: g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
			6'd16: g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
			6'd17: g = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
			6'd18: g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
			6'd19: g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
			6'd20: g = {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
			6'd21: g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
			6'd22: g = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
			6'd23: g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
			6'd24: g = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
			6'd25: g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
			6'd26: g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
			6'd27: g = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
			6'd28: g = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
			6'd29: g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
			6'd30: g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
			6'd31: g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
			6'd32: g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
			6'd33: g = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
			6'd34: g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
			6'd35: g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
			6'd36: g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
			6'd37: g = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
			6'd38: g = {7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
			6'd39: g = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
			6'd40: g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
			6'd41: g = {7'h23, 7'h13, 7'h08, 7'h64, 7'h62};
			default: g = '0;
		endcase
		return g;
	endfunction

	function automatic glyph_col_t font_column(input glyph_idx_t idx, input logic [2:0] gx);
		glyph_bits_t g;
		glyph_col_t col;
		g = font_bits(idx);
		unique case (gx)
			3'd0: col = g[34:28];
			3'd1: col = g[27:21];
			3'd2: col = g[20:14];
			3'd3: col = g[13:7];
			3'd4: col = g[6:0];
			default: col = '0;
		endcase
		return col;
	endfunction

endpackage

>>> rtl/tocg_cell_mem.sv
// Cell store: glyph index memory with registered read, plus per-cell valid flags.
// Depends on tocg_pkg for the command struct and glyph index type.

module tocg_cell_mem import tocg_pkg::*; #(
	parameter int CELLS  = 240,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  mem_cmd_t          cmd,
	input  logic [ADDR_W-1:0] addr,
	input  glyph_idx_t        wr_glyph,
	output glyph_idx_t        rd_glyph_s2,
	output logic              rd_valid_s2
);

	glyph_idx_t       glyph_mem [CELLS];
	logic [CELLS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (cmd.write)
				glyph_mem[addr] <= wr_glyph;
			rd_glyph_s2 <= glyph_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			if (cmd.clear)
				valid_q <= '0;
			else if (cmd.write)
				valid_q[addr] <= 1'b1;
			else if (cmd.erase)
				valid_q[addr] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			rd_valid_s2 <= valid_q[addr];
	end

endmodule

>>> rtl/tocg_pixel.sv
// Pixel stage: font ROM lookup on the fetched glyph and the result output register.
// Depends on tocg_pkg for the font tables.

module tocg_pixel import tocg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       rd_s2,
	input  logic       pix_ok_s2,
	input  logic [2:0] gx_s2,
	input  logic [2:0] gy_s2,
	input  glyph_idx_t rd_glyph_s2,
	input  logic       rd_valid_s2,
	output logic       result_valid,
	output logic [7:0] coverage
);

	glyph_col_t col;
	logic       lit;
	logic       result_valid_q;
	logic [7:0] coverage_q;

	assign col = font_column(rd_glyph_s2, gx_s2);
	assign lit = pix_ok_s2 && rd_valid_s2 && col[gy_s2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (en)
			result_valid_q <= rd_s2;
	end

	always_ff @(posedge clk) begin
		if (en)
			coverage_q <= lit ? LIT : DARK;
	end

	assign result_valid = result_valid_q;
	assign coverage     = coverage_q;

endmodule

>>> rtl/text_overlay_character_generator.sv
// Top level of the text overlay character generator: decode, cell store and pixel stage.
// Depends on tocg_pkg, tocg_cell_mem and tocg_pixel.
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_stall     opcode char_code cell_row cell_column
//                                                   pixel_x pixel_y
//  result    out        result_valid / result_stall coverage
//
// One item enters per cycle while item_stall is low; a read's result is presented once it
// has passed the decode register (loaded at the transfer), then the cell memory read
// port, then the output register.
// Reads and writes of the same cell are ordered by the single memory access stage.
// Reset clears every cell at once; no item is refused after reset.
// A stalled result freezes the whole pipeline and raises item_stall.

module text_overlay_character_generator import tocg_pkg::*; #(
	parameter int TEXT_COLUMNS = 40,
	parameter int TEXT_ROWS    = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] char_code,
	input  logic [2:0] cell_row,
	input  logic [5:0] cell_column,
	input  logic [7:0] pixel_x,
	input  logic [5:0] pixel_y,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] coverage
);

	localparam int CELLS  = TEXT_ROWS * TEXT_COLUMNS;
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	logic              en;
	logic [15:0]       x_prod;
	logic [5:0]        x_col;
	logic [2:0]        gx;
	logic              pix_ok;
	logic              cell_ok;
	glyph_idx_t        wr_glyph;
	logic              known;
	logic [ADDR_W-1:0] addr;
	mem_cmd_t          cmd;

	mem_cmd_t          cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	glyph_idx_t        glyph_s1;
	logic              pix_ok_s1;
	logic [2:0]        gx_s1;
	logic [2:0]        gy_s1;

	logic              rd_s2;
	logic              pix_ok_s2;
	logic [2:0]        gx_s2;
	logic [2:0]        gy_s2;
	glyph_idx_t        rd_glyph_s2;
	logic              rd_valid_s2;

	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	// x / 6 by reciprocal, exact over the 8-bit range
	assign x_prod = 16'(pixel_x) * 16'd171;
	assign x_col  = x_prod[15:10];
	assign gx     = 3'(pixel_x - 8'(x_col) * 8'd6);

	assign pix_ok = (int'(pixel_x) < CELL_W * TEXT_COLUMNS) &&
	                (int'(pixel_y) < CELL_H * TEXT_ROWS) &&
	                (int'(gx) < GLYPH_W) && (int'(pixel_y[2:0]) < GLYPH_H);

	assign cell_ok  = (int'(cell_row) < TEXT_ROWS) && (int'(cell_column) < TEXT_COLUMNS);
	assign wr_glyph = glyph_index(char_code);
	assign known    = (wr_glyph != NO_GLYPH);

	always_comb begin
		if (opcode == OP_READ)
			addr = ADDR_W'(int'(pixel_y[5:3]) * TEXT_COLUMNS + int'(x_col));
		else
			addr = ADDR_W'(int'(cell_row) * TEXT_COLUMNS + int'(cell_column));
	end

	always_comb begin
		cmd = '0;
		if (item_valid) begin
			cmd.clear = (opcode == OP_CLEAR);
			cmd.write = (opcode == OP_WRITE) && cell_ok && known;
			cmd.erase = (opcode == OP_WRITE) && cell_ok && !known;
			cmd.read  = (opcode == OP_READ);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			rd_s2  <= 1'b0;
		end else if (en) begin
			cmd_s1 <= cmd;
			rd_s2  <= cmd_s1.read;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1   <= addr;
			glyph_s1  <= wr_glyph;
			pix_ok_s1 <= pix_ok;
			gx_s1     <= gx;
			gy_s1     <= pixel_y[2:0];
			pix_ok_s2 <= pix_ok_s1;
			gx_s2     <= gx_s1;
			gy_s2     <= gy_s1;
		end
	end

	tocg_cell_mem #(
		.CELLS  (CELLS),
		.ADDR_W (ADDR_W)
	) u_cell_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.cmd         (cmd_s1),
		.addr        (addr_s1),
		.wr_glyph    (glyph_s1),
		.rd_glyph_s2 (rd_glyph_s2),
		.rd_valid_s2 (rd_valid_s2)
	);

	tocg_pixel u_pixel (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.rd_s2        (rd_s2),
		.pix_ok_s2    (pix_ok_s2),
		.gx_s2        (gx_s2),
		.gy_s2        (gy_s2),
		.rd_glyph_s2  (rd_glyph_s2),
		.rd_valid_s2  (rd_valid_s2),
		.result_valid (result_valid),
		.coverage     (coverage)
	);

endmodule

>>> rtl/tocg_checker.sv
// Port-level checks for the text overlay character generator, bound to the top level.
// Depends on tocg_pkg for the read opcode.

module tocg_checker import tocg_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic [1:0] opcode,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] coverage
);

	a_cov_levels: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (coverage == LIT || coverage == DARK))
		else $error("coverage neither lit nor dark");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("item stalled without a blocked result");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(result_valid) && !$past(item_stall, 1) && !$past(item_stall, 2) &&
		 !$past(item_stall, 3))
		|-> $past(item_valid && !item_stall && opcode == OP_READ, 3))
		else $error("result without a read transfer");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(coverage)))
		else $error("stalled result changed");

endmodule

bind text_overlay_character_generator tocg_checker u_tocg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.opcode       (opcode),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.coverage     (coverage)
);
